/* hdl/i2csw_pkg.sv */
// Shared types, reset constants and helpers for the I2C slave write receiver.
// Depends on nothing; every other file in hdl/ refers to it by scoped names.
package i2csw_pkg;

    localparam int ADDR_W  = 7;
    localparam int BYTE_W  = 8;
    localparam int BITCNT_W = 4;

    // Reset values of the configuration registers.
    localparam logic [ADDR_W-1:0] OWN_ADDRESS_RESET = 7'h58;
    localparam logic [BYTE_W-1:0] BYTES_PER_XFER_RESET = 8'd10;

    // Configuration register indexes.
    typedef enum logic {
        CFG_OWN_ADDRESS    = 1'b0,
        CFG_BYTES_PER_XFER = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_ADDR     = 3'd1,
        PH_ADDR_ACK = 3'd2,
        PH_DATA     = 3'd3,
        PH_DATA_ACK = 3'd4
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic                prev_scl;
        logic                prev_sda;
        logic [BITCNT_W-1:0] bit_count;
        logic [BYTE_W-1:0]   shift_reg;
        logic [BYTE_W-1:0]   byte_count;
        logic                ack_drive;
    } rx_state_t;

    typedef struct packed {
        logic              sda_pull_low;
        logic              byte_valid;
        logic [BYTE_W-1:0] byte_value;
        logic [BYTE_W-1:0] byte_index;
        logic              last_byte;
        logic              address_matched;
    } rx_result_t;

    typedef struct packed {
        logic [ADDR_W-1:0] own_address;
        logic [BYTE_W-1:0] bytes_per_transfer;
    } rx_cfg_t;

    localparam rx_state_t STATE_RESET = '{
        phase:      PH_IDLE,
        prev_scl:   1'b1,
        prev_sda:   1'b1,
        bit_count:  '0,
        shift_reg:  '0,
        byte_count: '0,
        ack_drive:  1'b0
    };

    // Clears the frame state but keeps the previous line samples.
    function automatic rx_state_t go_idle(input rx_state_t st);
        rx_state_t r;
        r = st;
        r.phase      = PH_IDLE;
        r.bit_count  = '0;
        r.shift_reg  = '0;
        r.byte_count = '0;
        r.ack_drive  = 1'b0;
        return r;
    endfunction

endpackage

/* hdl/i2csw_cfg.sv */
// Configuration registers (own address and bytes per transfer) of the receiver.
// Depends on i2csw_pkg.
module i2csw_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_index,
    input  logic [i2csw_pkg::BYTE_W-1:0]  cfg_data,
    output i2csw_pkg::rx_cfg_t            cfg
);

    i2csw_pkg::rx_cfg_t cfg_reg;
    i2csw_pkg::rx_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (i2csw_pkg::cfg_index_t'(cfg_index))
                i2csw_pkg::CFG_OWN_ADDRESS:
                    cfg_next.own_address = cfg_data[i2csw_pkg::ADDR_W-1:0];
                i2csw_pkg::CFG_BYTES_PER_XFER:
                    cfg_next.bytes_per_transfer = cfg_data;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_address        <= i2csw_pkg::OWN_ADDRESS_RESET;
            cfg_reg.bytes_per_transfer <= i2csw_pkg::BYTES_PER_XFER_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/i2csw_step.sv */
// Next-state and result logic for one SCL/SDA sample of the receiver.
// Purely combinational; depends on i2csw_pkg.
module i2csw_step (
    input  i2csw_pkg::rx_state_t  state,
    input  i2csw_pkg::rx_cfg_t    cfg,
    input  logic                  scl,
    input  logic                  sda,
    output i2csw_pkg::rx_state_t  state_next,
    output i2csw_pkg::rx_result_t result
);

    logic                            rising;
    logic                            falling;
    logic                            scl_high;
    logic                            start_cond;
    logic                            stop_cond;
    logic [i2csw_pkg::BYTE_W:0]      total;
    logic [i2csw_pkg::BYTE_W:0]      count_inc;
    logic [i2csw_pkg::BYTE_W-1:0]    shift_in;
    i2csw_pkg::rx_state_t            nx;

    assign rising     = !state.prev_scl && scl;
    assign falling    = state.prev_scl && !scl;
    assign scl_high   = state.prev_scl && scl;
    assign start_cond = scl_high && state.prev_sda && !sda;
    assign stop_cond  = scl_high && !state.prev_sda && sda;

    // A byte count of zero behaves as one.
    assign total     = (cfg.bytes_per_transfer == '0) ? 9'd1
                                                       : {1'b0, cfg.bytes_per_transfer};
    assign count_inc = {1'b0, state.byte_count} + 9'd1;
    assign shift_in  = {state.shift_reg[i2csw_pkg::BYTE_W-2:0], sda};

    always_comb
    begin
        nx     = state;
        result = '0;

        if (start_cond)
        begin
            nx       = i2csw_pkg::go_idle(state);
            nx.phase = i2csw_pkg::PH_ADDR;
        end
        else if (stop_cond)
        begin
            nx = i2csw_pkg::go_idle(state);
        end
        else
        begin
            case (state.phase)
                i2csw_pkg::PH_ADDR, i2csw_pkg::PH_DATA:
                begin
                    if (rising && !state.bit_count[3])
                    begin
                        nx.shift_reg = shift_in;
                        nx.bit_count = state.bit_count + 4'd1;
                        if (state.bit_count == 4'd7)
                        begin
                            if (state.phase == i2csw_pkg::PH_ADDR)
                            begin
                                if (shift_in[7:1] == cfg.own_address)
                                    result.address_matched = 1'b1;
                                else
                                    nx = i2csw_pkg::go_idle(state);
                            end
                            else
                            begin
                                result.byte_valid = 1'b1;
                                result.byte_value = shift_in;
                                result.byte_index = state.byte_count;
                                result.last_byte  = (count_inc == total);
                            end
                        end
                    end
                    else if (falling && state.bit_count[3])
                    begin
                        nx.ack_drive = 1'b1;
                        nx.bit_count = '0;
                        nx.phase     = (state.phase == i2csw_pkg::PH_ADDR)
                                       ? i2csw_pkg::PH_ADDR_ACK : i2csw_pkg::PH_DATA_ACK;
                    end
                end

                i2csw_pkg::PH_ADDR_ACK, i2csw_pkg::PH_DATA_ACK:
                begin
                    if (rising)
                    begin
                        nx.bit_count = 4'd1;
                    end
                    else if (falling && state.bit_count != '0)
                    begin
                        nx.ack_drive = 1'b0;
                        nx.bit_count = '0;
                        if (state.phase == i2csw_pkg::PH_ADDR_ACK)
                        begin
                            // Only a write (R/W bit low) continues into data.
                            if (!state.shift_reg[0])
                            begin
                                nx.phase      = i2csw_pkg::PH_DATA;
                                nx.shift_reg  = '0;
                                nx.byte_count = '0;
                            end
                            else
                            begin
                                nx = i2csw_pkg::go_idle(state);
                            end
                        end
                        else if (count_inc >= total)
                        begin
                            nx = i2csw_pkg::go_idle(state);
                        end
                        else
                        begin
                            nx.phase      = i2csw_pkg::PH_DATA;
                            nx.shift_reg  = '0;
                            nx.byte_count = count_inc[i2csw_pkg::BYTE_W-1:0];
                        end
                    end
                end

                i2csw_pkg::PH_IDLE:
                begin
                    nx = state;
                end

                default:
                begin
                    nx = i2csw_pkg::go_idle(state);
                end
            endcase
        end

        nx.prev_scl         = scl;
        nx.prev_sda         = sda;
        result.sda_pull_low = nx.ack_drive;
    end

    assign state_next = nx;

endmodule

/* hdl/i2c_slave_write_receiver_top.sv */
// A sample moves from the input register into the result register, which then
// holds its result item. Throughput: one item every cycle unless out_ready stalls.
// The frame state is updated as a sample moves from the input register into
// the result register, so each sample sees the state left by the one before.
// Reset (rst_n low, asynchronous) empties both registers, returns the frame
// state to idle with both previous line samples high, and loads the default
// configuration (address 0x58, ten bytes per transfer).
module i2c_slave_write_receiver_top (
    input  logic                         clk,
    input  logic                         rst_n,

    // Pin sample channel.
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         scl_level,
    input  logic                         sda_level,

    // Result channel, one item per sample.
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         sda_pull_low,
    output logic                         byte_valid,
    output logic [i2csw_pkg::BYTE_W-1:0] byte_value,
    output logic [i2csw_pkg::BYTE_W-1:0] byte_index,
    output logic                         last_byte,
    output logic                         address_matched,

    // Configuration write channel.
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [i2csw_pkg::BYTE_W-1:0] cfg_data
);

    // Input register: holds one sample until it can move on.
    logic                  in_valid_reg;
    logic                  scl_reg;
    logic                  sda_reg;

    // Frame state and result register.
    i2csw_pkg::rx_state_t  state_reg;
    i2csw_pkg::rx_state_t  state_next;
    i2csw_pkg::rx_result_t result_reg;
    i2csw_pkg::rx_result_t result_next;
    logic                  out_valid_reg;

    i2csw_pkg::rx_cfg_t    cfg;
    logic                  advance;

    // The sample in the input register moves on whenever the result register
    // is empty or its item is taken in the same cycle. The input register can
    // therefore take a new item in every cycle while the output keeps flowing.
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    i2csw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    i2csw_step u_step (
        .state      (state_reg),
        .cfg        (cfg),
        .scl        (scl_reg),
        .sda        (sda_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Control registers of the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= i2csw_pkg::STATE_RESET;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (advance)
                state_reg <= state_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            scl_reg <= scl_level;
            sda_reg <= sda_level;
        end
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid       = out_valid_reg;
    assign sda_pull_low    = result_reg.sda_pull_low;
    assign byte_valid      = result_reg.byte_valid;
    assign byte_value      = result_reg.byte_value;
    assign byte_index      = result_reg.byte_index;
    assign last_byte       = result_reg.last_byte;
    assign address_matched = result_reg.address_matched;

endmodule

/* sim/i2c_slave_write_receiver_top_tb.sv */
// Self-checking testbench for the oversampled I2C slave write receiver.
// Depends on hdl/i2csw_pkg.sv and hdl/i2c_slave_write_receiver_top.sv.
`timescale 1ns / 100ps

module i2c_slave_write_receiver_top_tb;

    // Limit on consecutive cycles with no handshake on any channel.
    localparam int STALL_LIMIT = 2000;

    // Tracks the frame decoder one pin sample at a time and keeps the result
    // items that the block owes, oldest first.
    class i2c_rx_scoreboard;
        i2csw_pkg::phase_t     bus_phase;
        bit                    last_scl;
        bit                    last_sda;
        logic [3:0]            bit_cnt;
        logic [7:0]            shifter;
        logic [7:0]            byte_cnt;
        bit                    ack_on;
        logic [6:0]            own_addr;
        logic [7:0]            byte_total;
        i2csw_pkg::rx_result_t due_results[$];
        int                    mismatches;
        int                    samples_seen;
        int                    bytes_seen;
        int                    matches_seen;

        function new();
            own_addr   = i2csw_pkg::OWN_ADDRESS_RESET;
            byte_total = i2csw_pkg::BYTES_PER_XFER_RESET;
            clear_frame();
            last_scl   = 1'b1;
            last_sda   = 1'b1;
        endfunction

        function void clear_frame();
            bus_phase = i2csw_pkg::PH_IDLE;
            bit_cnt   = '0;
            shifter   = '0;
            byte_cnt  = '0;
            ack_on    = 1'b0;
        endfunction

        function void set_register(i2csw_pkg::cfg_index_t idx, logic [7:0] data);
            if (idx == i2csw_pkg::CFG_OWN_ADDRESS)
                own_addr = data[6:0];
            else
                byte_total = data;
        endfunction

        // Advances the decoder by one sample and queues the result item it owes.
        function void note_sample(bit scl, bit sda);
            i2csw_pkg::rx_result_t exp;
            bit                    rising;
            bit                    falling;
            bit                    held_high;
            int                    span;
            rising    = !last_scl && scl;
            falling   = last_scl && !scl;
            held_high = last_scl && scl;
            span      = (byte_total == 0) ? 1 : int'(byte_total);
            exp       = '0;
            if (held_high && last_sda && !sda)
            begin
                clear_frame();
                bus_phase = i2csw_pkg::PH_ADDR;
            end
            else if (held_high && !last_sda && sda)
            begin
                clear_frame();
            end
            else if (bus_phase == i2csw_pkg::PH_ADDR || bus_phase == i2csw_pkg::PH_DATA)
            begin
                if (rising && bit_cnt < 8)
                begin
                    shifter = {shifter[6:0], sda};
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt == 8)
                    begin
                        if (bus_phase == i2csw_pkg::PH_ADDR)
                        begin
                            if (shifter[7:1] == own_addr)
                                exp.address_matched = 1'b1;
                            else
                                clear_frame();
                        end
                        else
                        begin
                            exp.byte_valid = 1'b1;
                            exp.byte_value = shifter;
                            exp.byte_index = byte_cnt;
                            exp.last_byte  = (int'(byte_cnt) + 1 == span);
                        end
                    end
                end
                else if (falling && bit_cnt >= 8)
                begin
                    ack_on  = 1'b1;
                    bit_cnt = '0;
                    if (bus_phase == i2csw_pkg::PH_ADDR)
                        bus_phase = i2csw_pkg::PH_ADDR_ACK;
                    else
                        bus_phase = i2csw_pkg::PH_DATA_ACK;
                end
            end
            else if (bus_phase == i2csw_pkg::PH_ADDR_ACK ||
                     bus_phase == i2csw_pkg::PH_DATA_ACK)
            begin
                if (rising)
                begin
                    bit_cnt = 4'd1;
                end
                else if (falling && bit_cnt != 0)
                begin
                    ack_on  = 1'b0;
                    bit_cnt = '0;
                    if (bus_phase == i2csw_pkg::PH_ADDR_ACK)
                    begin
                        // A read request is acknowledged but not served.
                        if (!shifter[0])
                        begin
                            bus_phase = i2csw_pkg::PH_DATA;
                            shifter   = '0;
                            byte_cnt  = '0;
                        end
                        else
                        begin
                            clear_frame();
                        end
                    end
                    else
                    begin
                        byte_cnt = byte_cnt + 8'd1;
                        shifter  = '0;
                        if (int'(byte_cnt) >= span)
                            clear_frame();
                        else
                            bus_phase = i2csw_pkg::PH_DATA;
                    end
                end
            end
            else if (bus_phase != i2csw_pkg::PH_IDLE)
            begin
                clear_frame();
            end
            last_scl = scl;
            last_sda = sda;
            exp.sda_pull_low = ack_on;
            due_results.push_back(exp);
            samples_seen++;
        endfunction

        function void check_field(string name, logic [7:0] exp, logic [7:0] act);
            if (act !== exp)
            begin
                $error("%s: expected %0d, got %0d", name, exp, act);
                mismatches++;
            end
        endfunction

        function void check_result(i2csw_pkg::rx_result_t got);
            i2csw_pkg::rx_result_t exp;
            if (due_results.size() == 0)
            begin
                $error("result item arrived with no sample waiting for it");
                mismatches++;
            end
            else
            begin
                exp = due_results.pop_front();
                bytes_seen   += int'(exp.byte_valid);
                matches_seen += int'(exp.address_matched);
                check_field("sda_pull_low", 8'(exp.sda_pull_low), 8'(got.sda_pull_low));
                check_field("byte_valid", 8'(exp.byte_valid), 8'(got.byte_valid));
                check_field("byte_value", exp.byte_value, got.byte_value);
                check_field("byte_index", exp.byte_index, got.byte_index);
                check_field("last_byte", 8'(exp.last_byte), 8'(got.last_byte));
                check_field("address_matched", 8'(exp.address_matched),
                            8'(got.address_matched));
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic                          scl_level;
    logic                          sda_level;
    logic                          out_valid;
    logic                          out_ready;
    logic                          sda_pull_low;
    logic                          byte_valid;
    logic [i2csw_pkg::BYTE_W-1:0]  byte_value;
    logic [i2csw_pkg::BYTE_W-1:0]  byte_index;
    logic                          last_byte;
    logic                          address_matched;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic                          cfg_index;
    logic [i2csw_pkg::BYTE_W-1:0]  cfg_data;

    i2c_rx_scoreboard    board;

    // Percentages of cycles in which the sample source idles and the result
    // sink stalls; each traffic phase sets its own pair.
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  quiet_cycles;

    i2c_slave_write_receiver_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .scl_level       (scl_level),
        .sda_level       (sda_level),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .sda_pull_low    (sda_pull_low),
        .byte_valid      (byte_valid),
        .byte_value      (byte_value),
        .byte_index      (byte_index),
        .last_byte       (last_byte),
        .address_matched (address_matched),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The sink decides at each falling edge whether to take a result item
    // in the next cycle.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Results are sampled at the rising edge, before the block's registers
    // move, and checked in order against the queued predictions.
    always @(posedge clk)
    begin : result_monitor
        i2csw_pkg::rx_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.sda_pull_low    = sda_pull_low;
            got.byte_valid      = byte_valid;
            got.byte_value      = byte_value;
            got.byte_index      = byte_index;
            got.last_byte       = last_byte;
            got.address_matched = address_matched;
            board.check_result(got);
        end
    end

    // Watchdog: a hung handshake on every channel at once ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offers one pin sample, with random idle cycles in front of it, and
    // holds it until the block takes it. Called and returns at a falling edge.
    task automatic send_sample(input bit scl, input bit sda);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        scl_level <= scl;
        sda_level <= sda;
        do @(posedge clk); while (!in_ready);
        board.note_sample(scl, sda);
        @(negedge clk);
    endtask

    // Most bus levels last one sample; some are stretched to exercise the
    // edge detector on held levels.
    function automatic int level_len();
        return ($urandom_range(99) < 80) ? 1 : int'($urandom_range(3, 2));
    endfunction

    // One SCL clock with SDA steady across the high part.
    task automatic send_bit(input bit b);
        repeat (level_len()) send_sample(1'b0, b);
        repeat (level_len()) send_sample(1'b1, b);
    endtask

    // Sends the top nbits of a byte, MSB first; fewer than eight leaves the
    // byte broken off for a stop or a restart to interrupt.
    task automatic send_byte(input logic [7:0] data, input int nbits);
        for (int k = 7; k > 7 - nbits; k--)
            send_bit(data[k]);
    endtask

    // SDA is raised while SCL is low, so the start itself is the only
    // transition with SCL high.
    task automatic bus_start();
        send_sample(1'b0, 1'b1);
        send_sample(1'b1, 1'b1);
        send_sample(1'b1, 1'b0);
    endtask

    task automatic bus_stop();
        send_sample(1'b0, 1'b0);
        send_sample(1'b1, 1'b0);
        send_sample(1'b1, 1'b1);
    endtask

    // Stops offering samples and waits for every owed result, then lets the
    // two pipeline stages settle before anything else touches the block.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input i2csw_pkg::cfg_index_t idx, input logic [7:0] data);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        board.set_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A mostly well-formed write: start, address (usually ours), up to five data
    // bytes with ACK bits, then a stop, a repeated start or line noise.
    // Some frames break off mid-byte, and some carry the read bit.
    task automatic random_frame();
        logic [6:0] addr;
        bit         rw;
        int         span;
        int         nbytes;
        int         cut;
        span   = (board.byte_total == 0) ? 1 : int'(board.byte_total);
        addr   = ($urandom_range(99) < 75) ? board.own_addr : 7'($urandom);
        rw     = ($urandom_range(99) < 85) ? 1'b0 : 1'b1;
        nbytes = int'($urandom_range((span < 5) ? span + 1 : 5, 0));
        cut    = ($urandom_range(99) < 15) ? int'($urandom_range(7, 0)) : 8;
        bus_start();
        if (cut < 8 && nbytes == 0)
        begin
            send_byte({addr, rw}, cut);
        end
        else
        begin
            send_byte({addr, rw}, 8);
            send_bit(1'($urandom_range(1)));
            for (int i = 0; i < nbytes; i++)
            begin
                send_byte(8'($urandom), (i == nbytes - 1) ? cut : 8);
                if (i < nbytes - 1 || cut == 8)
                    send_bit(1'($urandom_range(1)));
            end
        end
        case ($urandom_range(9))
            6, 7: ;   // the next frame's start acts as a repeated start
            8, 9: repeat ($urandom_range(12, 3))
                      send_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
            default: bus_stop();
        endcase
    endtask

    // One traffic phase: program both registers while the block is idle,
    // then run random frames under the given idling pattern.
    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input logic [7:0] addr, input logic [7:0] total, input int n);
        int goal;
        write_register(i2csw_pkg::CFG_OWN_ADDRESS, addr);
        write_register(i2csw_pkg::CFG_BYTES_PER_XFER, total);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        goal = board.samples_seen + n;
        while (board.samples_seen < goal)
            random_frame();
    endtask

    initial
    begin
        board          = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        scl_level      = 1'b1;
        sda_level      = 1'b1;
        out_ready      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = i2csw_pkg::CFG_OWN_ADDRESS;
        cfg_data       = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames on the reset configuration. A matched write with
        // the all-ones and all-zeros data bytes, then a matched read that is
        // acknowledged and dropped, then a foreign address followed by a
        // restart and a stop in the middle of the address byte.
        bus_start();
        send_byte({7'h58, 1'b0}, 8);
        send_bit(1'b0);
        send_byte(8'hFF, 8);
        send_bit(1'b0);
        send_byte(8'h00, 8);
        send_bit(1'b0);
        bus_stop();
        bus_start();
        send_byte({7'h58, 1'b1}, 8);
        send_bit(1'b0);
        send_bit(1'b1);
        bus_stop();
        bus_start();
        send_byte({7'h27, 1'b0}, 8);
        send_bit(1'b1);
        bus_start();
        send_byte({7'h58, 1'b0}, 3);
        bus_stop();

        // Random traffic. The register settings cover both address extremes,
        // a byte count of zero (treated as one), one, and the largest count.
        run_phase(0, 0, 8'd0, 8'd1, 70);
        run_phase(54, 0, 8'd127, 8'd0, 70);
        run_phase(0, 54, 8'($urandom_range(127)), 8'd3, 70);
        run_phase(10, 10, 8'h58, 8'd255, 70);
        run_phase(0, 0, 8'($urandom_range(127)), 8'd2, 70);

        drain_results();
        repeat (8) @(negedge clk);
        if (board.pending() != 0)
        begin
            $error("%0d expected result items never arrived", board.pending());
            board.mismatches++;
        end

        $display("Checked %0d pin samples: %0d data bytes and %0d address matches,",
                 board.samples_seen, board.bytes_seen, board.matches_seen);
        $display("over six register settings and four sender/receiver idling patterns.");
        if (board.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
